// ----- hdl/wosc_pkg.sv -----
// Shared types and constants for the waveform oscillator.
package wosc_pkg;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2
  } wave_t;

  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t CFG_WAVEFORM = 1'b0;
  localparam cfg_idx_t CFG_INV_RATE = 1'b1;

  localparam int unsigned FREQ_W   = 24;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned SAMPLE_W = 16;

  localparam logic [RATE_W-1:0] INV_RATE_RST = 32'd22906492;

endpackage

// ----- hdl/wosc_shape.sv -----
// Waveform evaluation of one phase value: sine table, square, saw, zero otherwise.
module wosc_shape #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wosc_pkg::wave_t              waveform,
  input  logic [31:0]                  phase,
  output logic signed [15:0]           sample
);
  import wosc_pkg::*;

  localparam int unsigned QBITS = SINE_TABLE_BITS - 2;
  localparam int unsigned QLEN  = 1 << QBITS;
  localparam int unsigned QIW   = QBITS + 1;

  function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned qb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    x    = (64'(k) * 64'd1686629713 + (64'd1 << (qb - 1))) >> qb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      unique case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  logic [14:0] qtab [QLEN+1];

  for (genvar k = 0; k <= QLEN; k++) begin : g_qtab
    localparam logic [14:0] QV = quarter_sine(k, QBITS);
    assign qtab[k] = QV;
  end

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QBITS-1:0]           rem;
  logic [QIW-1:0]             qi;
  logic [14:0]                mag;
  logic signed [15:0]         sine;

  always_comb begin
    idx  = phase[31 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    rem  = idx[QBITS-1:0];
    qi   = quad[0] ? (QIW'(QLEN) - {1'b0, rem}) : {1'b0, rem};
    mag  = qtab[qi];
    sine = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    unique case (waveform)
      WAVE_SINE:   sample = sine;
      WAVE_SQUARE: sample = $signed({~phase[31], {15{phase[31]}}});
      WAVE_SAW:    sample = $signed({~phase[31], phase[30:16]});
      default:     sample = '0;
    endcase
  end

endmodule

// ----- hdl/waveform_oscillator_unit.sv -----
// Phase-accumulator oscillator: one chunk of samples per frequency item.
// Path: an item goes from the product register to the pending increment register,
// then to the generator's register; its samples leave through the output register.
// Throughput: CHUNK_SIZE samples per item, counted by the sample counter, one
// sample per cycle unless the output stalls; the next increment is prepared as a chunk runs.
// Reset: synchronous active low; phase to zero, waveform sine, inv_rate 22906492.
module waveform_oscillator_unit #(
  parameter int unsigned CHUNK_SIZE      = 64,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [23:0]             in_freq,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [15:0]      out_sample,
  output logic                    out_last,
  input  logic                    cfg_wr_en,
  input  wosc_pkg::cfg_idx_t      cfg_index,
  input  logic [31:0]             cfg_wdata
);
  import wosc_pkg::*;

  localparam int unsigned CW = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;

  wave_t                waveform_r;
  logic [RATE_W-1:0]    inv_rate_r;

  logic                 b_vld_r;
  logic                 b_vld_nxt;
  logic [47:0]          prod_r;
  logic [55:0]          prod_full;

  logic                 pend_vld_r;
  logic                 pend_vld_nxt;
  logic [PHASE_W-1:0]   pend_inc_r;
  logic [47:0]          rnd_sum;

  logic                 gen_vld_r;
  logic                 gen_vld_nxt;
  logic [PHASE_W-1:0]   inc_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cnt_nxt;
  logic [PHASE_W-1:0]   phase_r;
  logic [PHASE_W-1:0]   phase_nxt;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic signed [15:0]   out_sample_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic                 emit;
  logic                 cnt_last;
  logic                 gen_take;
  logic                 pend_ld;
  logic signed [15:0]   shape_sample;

  assign in_ready   = !b_vld_r;
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  assign prod_full = 56'(in_freq) * 56'(inv_rate_r);
  assign rnd_sum   = prod_r + 48'h8000;

  assign emit     = gen_vld_r && (!out_valid_r || out_ready);
  assign cnt_last = (cnt_r == CW'(CHUNK_SIZE - 1));
  assign gen_take = pend_vld_r && (!gen_vld_r || (emit && cnt_last));
  assign pend_ld  = b_vld_r && (!pend_vld_r || gen_take);

  wosc_shape #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_shape (
    .waveform(waveform_r),
    .phase   (phase_r),
    .sample  (shape_sample)
  );

  always_comb begin
    b_vld_nxt = b_vld_r;
    if (in_acc) begin
      b_vld_nxt = 1'b1;
    end else if (pend_ld) begin
      b_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    if (pend_ld) begin
      pend_vld_nxt = 1'b1;
    end else if (gen_take) begin
      pend_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    gen_vld_nxt = gen_vld_r;
    cnt_nxt     = cnt_r;
    phase_nxt   = phase_r;
    if (emit) begin
      phase_nxt = phase_r + inc_r;
      cnt_nxt   = cnt_r + CW'(1);
    end
    if (gen_take) begin
      gen_vld_nxt = 1'b1;
      cnt_nxt     = '0;
    end else if (emit && cnt_last) begin
      gen_vld_nxt = 1'b0;
      cnt_nxt     = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r <= WAVE_SINE;
      inv_rate_r <= INV_RATE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WAVEFORM: waveform_r <= wave_t'(cfg_wdata[1:0]);
        CFG_INV_RATE: inv_rate_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      gen_vld_r   <= 1'b0;
      cnt_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      b_vld_r     <= b_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      gen_vld_r   <= gen_vld_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod_r <= prod_full[47:0];
    end
    if (pend_ld) begin
      pend_inc_r <= rnd_sum[47:16];
    end
    if (gen_take) begin
      inc_r <= pend_inc_r;
    end
    if (emit) begin
      out_sample_r <= shape_sample;
      out_last_r   <= cnt_last;
    end
  end

  a_start_has_inc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(gen_vld_r) |-> $past(pend_vld_r))
    else $error("chunk started without a prepared increment");

  a_stall_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(phase_r))
    else $error("phase advanced while output stalled");

  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_vld_r && !gen_take) |=> (pend_vld_r && $stable(pend_inc_r)))
    else $error("pending increment lost or overwritten");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cnt_last) |=> (out_valid && out_last))
    else $error("final sample of chunk not marked last");

endmodule

// ----- dv/waveform_oscillator_unit_tb.sv -----
// Self-checking testbench for waveform_oscillator_unit: predicted sample chunks under backpressure.
module waveform_oscillator_unit_tb;
  import wosc_pkg::*;

  localparam int unsigned CHUNK = 64;
  localparam int unsigned TBL_BITS = 10;
  localparam int unsigned QB = TBL_BITS - 2;
  localparam int unsigned QLEN = 1 << QB;
  localparam logic [1:0] WAVE_UNUSED = 2'd3;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned RANDOM_ITEMS = 240;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [FREQ_W-1:0]          in_freq = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic                       cfg_wr_en = 1'b0;
  cfg_idx_t                   cfg_index = CFG_WAVEFORM;
  logic [RATE_W-1:0]          cfg_wdata = '0;

  logic [FREQ_W-1:0] freq_q[$];
  sample_t           sample_q[$];

  logic [PHASE_W-1:0] phase_m;
  logic [1:0]         wave_m;
  logic [RATE_W-1:0]  rate_m;
  logic [15:0]        quarter [0:QLEN];

  logic        in_took = 1'b0;
  logic        steady = 1'b0;
  logic        stall_kick = 1'b0;
  logic        stall_done = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 1;

  waveform_oscillator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_freq    (in_freq),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .out_last   (out_last),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] quarter_sine(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          s;
    x = (longint'(k) * HALF_PI_Q30 + (64'd1 << (QB - 1))) >> QB;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int unsigned n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        s -= longint'(term);
      end else begin
        s += longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    v = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] wave_at(logic [PHASE_W-1:0] ph);
    logic [TBL_BITS-1:0] idx;
    logic [1:0]          quad;
    logic [QB-1:0]       r;
    logic signed [15:0]  m;
    idx = ph[PHASE_W-1 -: TBL_BITS];
    quad = idx[TBL_BITS-1 -: 2];
    r = idx[QB-1:0];
    m = quad[0] ? quarter[QLEN - r] : quarter[r];
    case (wave_m)
      WAVE_SINE:   return quad[1] ? -m : m;
      WAVE_SQUARE: return ph[PHASE_W-1] ? 16'sh7FFF : 16'sh8000;
      WAVE_SAW:    return ph[PHASE_W-1 -: 16] - 16'h8000;
      default:     return '0;
    endcase
  endfunction

  task automatic predict_chunk(logic [FREQ_W-1:0] f);
    logic [63:0] prod;
    logic [31:0] inc;
    sample_t     s;
    prod = 64'(f) * 64'(rate_m) + 64'h8000;
    inc = prod[47:16];
    for (int unsigned k = 0; k < CHUNK; k++) begin
      s.sample = wave_at(phase_m);
      s.last = (k == CHUNK - 1);
      sample_q.push_back(s);
      phase_m += inc;
    end
  endtask

  task automatic check_sample(logic signed [SAMPLE_W-1:0] got_s, logic got_l);
    sample_t e;
    n_checked++;
    if (sample_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected sample %0d last %0b with nothing pending", got_s, got_l);
      end
    end else begin
      e = sample_q.pop_front();
      if (got_s !== e.sample || got_l !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("sample %0d: expected %0d last %0b, got %0d last %0b",
                   n_checked, e.sample, e.last, got_s, got_l);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      check_sample(out_sample, out_last);
    end
    if (rst_n && in_valid && in_ready) begin
      predict_chunk(in_freq);
      n_items++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (freq_q.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
        in_valid <= 1'b1;
        in_freq <= freq_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_kick && !stall_done) begin
      stall_left = HOLD_OFF_CYCLES;
      stall_done = 1'b1;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || $urandom_range(99) >= 10;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [RATE_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_WAVEFORM) begin
      wave_m = val[1:0];
    end else begin
      rate_m = val;
    end
  endtask

  task automatic set_regs(logic [1:0] w, logic [RATE_W-1:0] r);
    write_reg(CFG_WAVEFORM, {30'b0, w});
    write_reg(CFG_INV_RATE, r);
    n_settings++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (freq_q.size() != 0 || in_valid || sample_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 3))
      0:       return FREQ_W'($urandom);
      1:       return FREQ_W'($urandom_range(0, 24'h4E2000));
      2:       return FREQ_W'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    endcase
  endfunction

  initial begin
    int unsigned       n_random;
    int unsigned       n_burst;
    int unsigned       phase_no;
    logic [1:0]        w;
    logic [RATE_W-1:0] r;
    for (int unsigned k = 0; k <= QLEN; k++) begin
      quarter[k] = quarter_sine(k);
    end
    phase_m = '0;
    wave_m = WAVE_SINE;
    rate_m = INV_RATE_RST;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    freq_q = '{24'h000000, 24'h01B800, 24'hFFFFFF, 24'h000001, 24'hAAAAAA, 24'h555555};
    wait_drained();
    set_regs(WAVE_SQUARE, 32'hFFFF_FFFF);
    freq_q = '{24'hFFFFFF, 24'h000100, 24'h123456};
    wait_drained();
    set_regs(WAVE_SAW, 32'd1);
    freq_q = '{24'hFFFFFF, 24'h000001, 24'h000000};
    wait_drained();
    set_regs(WAVE_UNUSED, 32'h5555_5555);
    freq_q = '{24'h55AA55, 24'hFFFFFF};
    wait_drained();
    set_regs(WAVE_SINE, 32'd0);
    freq_q = '{24'hFFFFFF, 24'h800000};
    wait_drained();
    set_regs(WAVE_SINE, 32'hAAAA_AAAA);
    freq_q = '{24'h0F0F0F, 24'h7FFFFF};
    wait_drained();

    n_random = 0;
    phase_no = 0;
    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: w = WAVE_SINE;
        3, 4, 5: w = WAVE_SQUARE;
        6, 7, 8: w = WAVE_SAW;
        default: w = WAVE_UNUSED;
      endcase
      case ($urandom_range(0, 5))
        0:       r = INV_RATE_RST;
        1:       r = $urandom_range(5_000_000, 140_000_000);
        2:       r = $urandom;
        3:       r = 32'hFFFF_FFFF;
        4:       r = $urandom_range(0, 255);
        default: r = 32'd1;
      endcase
      set_regs(w, r);
      n_burst = (phase_no == 1 || phase_no == 2) ? 25 : $urandom_range(8, 30);
      steady = (phase_no == 1);
      repeat (n_burst) freq_q.push_back(pick_freq());
      if (phase_no == 2) begin
        stall_kick = 1'b1;
      end
      n_random += n_burst;
      phase_no++;
      wait_drained();
    end
    steady = 1'b0;
    repeat (10) @(posedge clk);

    $display("%0d frequency items over %0d register settings, %0d samples checked",
             n_items, n_settings, n_checked);
    $display("shapes sine, square, saw and unused select; rate from 0 to all ones; one long hold-off");
    if (mismatches == 0 && sample_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
